/* rtl/core/radial_alpha_falloff_macros.svh */
// assertion macros used by the radial alpha falloff checker
`ifndef RADIAL_ALPHA_FALLOFF_MACROS_SVH
`define RADIAL_ALPHA_FALLOFF_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radial_alpha_falloff: assertion failed");

// antecedent implies consequent after the delay given by n
`define RAF_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("radial_alpha_falloff: assertion failed");

`endif

/* rtl/core/raf_pkg.sv */
// shared constants and types of the radial alpha falloff block
`default_nettype none

package raf_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int ALPHA_BITS         = 8;
    localparam int RADIUS_BITS        = 13;

    // 65536 / radius gives a 17-bit quotient, one bit per pipeline step
    localparam int DIVIDEND    = 65536;
    localparam int DIV_BITS    = 17;
    localparam int ATTEN_SHIFT = 8;

    // register stages before and after the step chain
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 2;
    localparam int LATENCY      = FRONT_STAGES + DIV_BITS + BACK_STAGES;

    localparam logic [ALPHA_BITS-1:0]  MAX_ALPHA_RESET = 8'd255;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET    = 13'd256;

    typedef enum logic [1:0] {
        REG_MAX_ALPHA  = 2'd0,
        REG_RADIUS     = 2'd1,
        REG_CENTER_COL = 2'd2,
        REG_CENTER_ROW = 2'd3
    } cfg_reg_t;

    // alpha fields that ride along with an item
    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha;
        logic [ALPHA_BITS-1:0] scaled;
    } side_t;

    // state of the reciprocal long division
    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic [RADIUS_BITS-1:0] rem;
        logic [DIV_BITS-1:0]    quot;
    } div_state_t;

endpackage

`default_nettype wire

/* rtl/core/radial_alpha_falloff.sv */
// top level of the radial alpha falloff pixel pipeline
`default_nettype none

// radial alpha falloff: one pixel enters per clock whenever start is high;
// busy stays low, so every cycle can carry a new pixel. each pixel comes
// back on new_alpha with a one-cycle done strobe after it has passed the
// 3 front stages, 17 steps and 2 back stages, in the order taken.
// the receiver has no way to hold results off and must take every strobe.
// in the 17-step chain each stage forms one bit of 65536 / falloff_radius
// and the last COORD_BITS + 1 stages also form one bit each of the
// distance square root.
// a pixel with alpha 0 comes out as 0; a falloff_radius of 0 acts as 1.
// configuration is written through cfg_write / cfg_index / cfg_data and may
// only change while no pixel is in flight.
module radial_alpha_falloff #(
    parameter int COORD_BITS = raf_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // item input
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [raf_pkg::ALPHA_BITS-1:0]         pixel_alpha,
    input  wire logic [COORD_BITS-1:0]                  pixel_row,
    input  wire logic [COORD_BITS-1:0]                  pixel_col,
    // result output
    output logic                                        done,
    output logic [raf_pkg::ALPHA_BITS-1:0]              new_alpha,
    // configuration write port
    input  wire logic                                   cfg_write,
    input  wire logic [1:0]                             cfg_index,
    input  wire logic [((COORD_BITS > raf_pkg::RADIUS_BITS) ?
                        COORD_BITS : raf_pkg::RADIUS_BITS)-1:0] cfg_data
);

    localparam int SQ_BITS = COORD_BITS + 1;
    localparam int NSTEP   = raf_pkg::DIV_BITS;

    // configuration registers
    logic [raf_pkg::ALPHA_BITS-1:0]    max_alpha_reg;
    logic [raf_pkg::RADIUS_BITS-1:0]   radius_reg;
    logic [COORD_BITS-1:0]             center_col_reg;
    logic [COORD_BITS-1:0]             center_row_reg;

    logic                              accept;

    // step chain links, index 0 is the front output
    logic                              valid_s [0:NSTEP];
    raf_pkg::side_t                    side_s  [0:NSTEP];
    raf_pkg::div_state_t               div_s   [0:NSTEP];
    logic [2*SQ_BITS-1:0]              v_s     [0:NSTEP];
    logic [SQ_BITS+2:0]                rem_s   [0:NSTEP];
    logic [SQ_BITS-1:0]                root_s  [0:NSTEP];

    logic [raf_pkg::RADIUS_BITS-1:0]   front_radius;

    // the pipeline never stalls, so the block is never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes, unknown indexes cannot occur with a 2-bit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_alpha_reg  <= raf_pkg::MAX_ALPHA_RESET;
            radius_reg     <= raf_pkg::RADIUS_RESET;
            center_col_reg <= '0;
            center_row_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (raf_pkg::cfg_reg_t'(cfg_index))
                raf_pkg::REG_MAX_ALPHA:  max_alpha_reg  <= cfg_data[raf_pkg::ALPHA_BITS-1:0];
                raf_pkg::REG_RADIUS:     radius_reg     <= cfg_data[raf_pkg::RADIUS_BITS-1:0];
                raf_pkg::REG_CENTER_COL: center_col_reg <= cfg_data[COORD_BITS-1:0];
                raf_pkg::REG_CENTER_ROW: center_row_reg <= cfg_data[COORD_BITS-1:0];
                default:                 max_alpha_reg  <= max_alpha_reg;
            endcase
        end
    end

    // offsets, squares, alpha scale and distance sum
    raf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .pixel_alpha    (pixel_alpha),
        .pixel_row      (pixel_row),
        .pixel_col      (pixel_col),
        .max_alpha      (max_alpha_reg),
        .falloff_radius (radius_reg),
        .center_col     (center_col_reg),
        .center_row     (center_row_reg),
        .out_valid      (valid_s[0]),
        .out_side       (side_s[0]),
        .out_radius     (front_radius),
        .out_sum        (v_s[0])
    );

    // division and square root both start from zero partial state
    assign div_s[0]  = '{radius: front_radius, rem: '0, quot: '0};
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    // quotient and root bits from the top bit down, one per stage
    generate
        for (genvar k = 0; k < NSTEP; k++)
        begin : g_step
            raf_step #(
                .SQ_BITS (SQ_BITS),
                .J       (NSTEP - 1 - k)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_s[k]),
                .in_side   (side_s[k]),
                .in_div    (div_s[k]),
                .in_v      (v_s[k]),
                .in_rem    (rem_s[k]),
                .in_root   (root_s[k]),
                .out_valid (valid_s[k+1]),
                .out_side  (side_s[k+1]),
                .out_div   (div_s[k+1]),
                .out_v     (v_s[k+1]),
                .out_rem   (rem_s[k+1]),
                .out_root  (root_s[k+1])
            );
        end
    endgenerate

    // distance times reciprocal, subtract from scaled alpha, clamp
    raf_back #(
        .SQ_BITS (SQ_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_s[NSTEP]),
        .in_side   (side_s[NSTEP]),
        .in_quot   (div_s[NSTEP].quot),
        .in_root   (root_s[NSTEP]),
        .out_valid (done),
        .out_alpha (new_alpha)
    );

endmodule

`default_nettype wire

/* rtl/core/raf_front.sv */
// front stages: center offsets, squares, alpha scaling and distance sum
`default_nettype none

module raf_front #(
    parameter int COORD_BITS = raf_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic [raf_pkg::ALPHA_BITS-1:0]      pixel_alpha,
    input  wire logic [COORD_BITS-1:0]               pixel_row,
    input  wire logic [COORD_BITS-1:0]               pixel_col,
    input  wire logic [raf_pkg::ALPHA_BITS-1:0]      max_alpha,
    input  wire logic [raf_pkg::RADIUS_BITS-1:0]     falloff_radius,
    input  wire logic [COORD_BITS-1:0]               center_col,
    input  wire logic [COORD_BITS-1:0]               center_row,
    output logic                                     out_valid,
    output raf_pkg::side_t                           out_side,
    output logic [raf_pkg::RADIUS_BITS-1:0]          out_radius,
    output logic [2*COORD_BITS+1:0]                  out_sum
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = 2 * COORD_BITS + 2;
    localparam int AW    = raf_pkg::ALPHA_BITS;

    // stage a
    logic                                 a_valid_reg;
    logic [AW-1:0]                        a_alpha_reg;
    logic [AW-1:0]                        a_max_reg;
    logic [raf_pkg::RADIUS_BITS-1:0]      a_radius_reg;
    logic [COORD_BITS-1:0]                a_dx_reg;
    logic [COORD_BITS-1:0]                a_dy_reg;
    logic [COORD_BITS-1:0]                dx_next;
    logic [COORD_BITS-1:0]                dy_next;
    logic [raf_pkg::RADIUS_BITS-1:0]      radius_next;

    // stage b
    logic                                 b_valid_reg;
    raf_pkg::side_t                       b_side_reg;
    logic [raf_pkg::RADIUS_BITS-1:0]      b_radius_reg;
    logic [SQ_W-1:0]                      b_sqx_reg;
    logic [SQ_W-1:0]                      b_sqy_reg;
    logic [2*AW-1:0]                      scale_prod;

    // stage c
    logic                                 c_valid_reg;
    raf_pkg::side_t                       c_side_reg;
    logic [raf_pkg::RADIUS_BITS-1:0]      c_radius_reg;
    logic [SUM_W-1:0]                     c_sum_reg;

    assign dx_next = (center_col >= pixel_col) ? (center_col - pixel_col)
                                               : (pixel_col - center_col);
    assign dy_next = (center_row >= pixel_row) ? (center_row - pixel_row)
                                               : (pixel_row - center_row);
    // zero radius acts as one
    assign radius_next = (falloff_radius == '0) ? raf_pkg::RADIUS_BITS'(1) : falloff_radius;

    assign scale_prod = (2*AW)'(a_alpha_reg) * (2*AW)'(a_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_alpha_reg  <= pixel_alpha;
        a_max_reg    <= max_alpha;
        a_radius_reg <= radius_next;
        a_dx_reg     <= dx_next;
        a_dy_reg     <= dy_next;

        b_side_reg.alpha  <= a_alpha_reg;
        b_side_reg.scaled <= scale_prod[2*AW-1:AW];
        b_radius_reg      <= a_radius_reg;
        b_sqx_reg         <= SQ_W'(a_dx_reg) * SQ_W'(a_dx_reg);
        b_sqy_reg         <= SQ_W'(a_dy_reg) * SQ_W'(a_dy_reg);

        c_side_reg   <= b_side_reg;
        c_radius_reg <= b_radius_reg;
        c_sum_reg    <= SUM_W'(b_sqx_reg) + SUM_W'(b_sqy_reg);
    end

    assign out_valid  = c_valid_reg;
    assign out_side   = c_side_reg;
    assign out_radius = c_radius_reg;
    assign out_sum    = c_sum_reg;

endmodule

`default_nettype wire

/* rtl/core/raf_step.sv */
// one pipeline step: one reciprocal quotient bit and, in the low SQ_BITS positions, one square root bit
`default_nettype none

module raf_step #(
    parameter int SQ_BITS = raf_pkg::COORD_BITS_DEFAULT + 1,
    parameter int J       = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire raf_pkg::side_t              in_side,
    input  wire raf_pkg::div_state_t         in_div,
    input  wire logic [2*SQ_BITS-1:0]        in_v,
    input  wire logic [SQ_BITS+2:0]          in_rem,
    input  wire logic [SQ_BITS-1:0]          in_root,
    output logic                             out_valid,
    output raf_pkg::side_t                   out_side,
    output raf_pkg::div_state_t              out_div,
    output logic [2*SQ_BITS-1:0]             out_v,
    output logic [SQ_BITS+2:0]               out_rem,
    output logic [SQ_BITS-1:0]               out_root
);

    localparam int RB    = raf_pkg::RADIUS_BITS;
    localparam int REM_W = SQ_BITS + 3;
    localparam logic [raf_pkg::DIV_BITS-1:0] DIVIDEND_VEC =
        raf_pkg::DIV_BITS'(raf_pkg::DIVIDEND);

    logic                    valid_reg;
    raf_pkg::side_t          side_reg;
    raf_pkg::div_state_t     div_reg;
    raf_pkg::div_state_t     div_next;
    logic [2*SQ_BITS-1:0]    v_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        rem_next;
    logic [SQ_BITS-1:0]      root_reg;
    logic [SQ_BITS-1:0]      root_next;

    logic [RB:0]             div_shift;
    logic [RB:0]             div_diff;
    logic                    div_ge;

    // restoring division step on 65536 / radius
    assign div_shift = {in_div.rem, DIVIDEND_VEC[J]};
    assign div_diff  = div_shift - {1'b0, in_div.radius};
    assign div_ge    = (div_shift >= {1'b0, in_div.radius});

    always_comb
    begin
        div_next        = in_div;
        div_next.rem    = div_ge ? div_diff[RB-1:0] : div_shift[RB-1:0];
        div_next.quot[J] = div_ge;
    end

    generate
        if (J < SQ_BITS)
        begin : g_sqrt
            logic [REM_W-1:0] sq_shift;
            logic [REM_W-1:0] sq_trial;
            logic             sq_ge;

            // bring down the next bit pair and try root*4+1
            assign sq_shift  = {in_rem[REM_W-3:0], in_v[2*J+1:2*J]};
            assign sq_trial  = REM_W'({in_root, 2'b01});
            assign sq_ge     = (sq_shift >= sq_trial);
            assign rem_next  = sq_ge ? (sq_shift - sq_trial) : sq_shift;
            assign root_next = {in_root[SQ_BITS-2:0], sq_ge};
        end
        else
        begin : g_pass
            // root not started yet at this bit position
            assign rem_next  = in_rem;
            assign root_next = in_root;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        div_reg  <= div_next;
        v_reg    <= in_v;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;
    assign out_v     = v_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

`default_nettype wire

/* rtl/core/raf_back.sv */
// back stages: attenuation product, subtract and clamp, result register
`default_nettype none

module raf_back #(
    parameter int SQ_BITS = raf_pkg::COORD_BITS_DEFAULT + 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire raf_pkg::side_t                     in_side,
    input  wire logic [raf_pkg::DIV_BITS-1:0]       in_quot,
    input  wire logic [SQ_BITS-1:0]                 in_root,
    output logic                                    out_valid,
    output logic [raf_pkg::ALPHA_BITS-1:0]          out_alpha
);

    localparam int AW      = raf_pkg::ALPHA_BITS;
    localparam int PROD_W  = SQ_BITS + raf_pkg::DIV_BITS;
    localparam int ATTEN_W = PROD_W - raf_pkg::ATTEN_SHIFT;

    logic                  p_valid_reg;
    raf_pkg::side_t        p_side_reg;
    logic [ATTEN_W-1:0]    p_atten_reg;
    logic [PROD_W-1:0]     prod;

    logic                  q_valid_reg;
    logic [AW-1:0]         q_alpha_reg;
    logic [AW-1:0]         alpha_next;
    logic [AW-1:0]         diff;

    assign prod = PROD_W'(in_root) * PROD_W'(in_quot);

    always_comb
    begin
        if (ATTEN_W'(p_side_reg.scaled) > p_atten_reg)
        begin
            diff = p_side_reg.scaled - p_atten_reg[AW-1:0];
        end
        else
        begin
            diff = '0;
        end
        // a result above the old alpha falls to zero
        alpha_next = (diff > p_side_reg.alpha) ? '0 : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_side_reg  <= in_side;
        p_atten_reg <= prod[PROD_W-1:raf_pkg::ATTEN_SHIFT];
        q_alpha_reg <= alpha_next;
    end

    assign out_valid = q_valid_reg;
    assign out_alpha = q_alpha_reg;

endmodule

`default_nettype wire

/* rtl/core/raf_checker.sv */
// port-level checker for the radial alpha falloff block and its bind
`default_nettype none

`include "radial_alpha_falloff_macros.svh"

module raf_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [raf_pkg::ALPHA_BITS-1:0]  pixel_alpha,
    input  wire logic                            done,
    input  wire logic [raf_pkg::ALPHA_BITS-1:0]  new_alpha
);

    localparam int LAT = raf_pkg::LATENCY;

    // every taken item comes out after the fixed latency
    `RAF_ASSERT_DELAY(a_item_out, clk, rst_n, start && !busy, LAT, done)

    // no strobe without an item taken the latency before
    `RAF_ASSERT_IMPLY(a_no_extra, clk, rst_n, done, $past(start && !busy, LAT))

    // a transparent pixel stays transparent
    `RAF_ASSERT_DELAY(a_zero_alpha, clk, rst_n, start && !busy && (pixel_alpha == '0), LAT, new_alpha == '0)

    // attenuation never raises alpha
    `RAF_ASSERT_IMPLY(a_no_gain, clk, rst_n, done, new_alpha <= $past(pixel_alpha, LAT))

endmodule

bind radial_alpha_falloff raf_checker u_raf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .pixel_alpha (pixel_alpha),
    .done        (done),
    .new_alpha   (new_alpha)
);

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the radial alpha falloff pipeline: directed and random pixels, checked in order
`timescale 1ns / 1ps

module tb_top;

    import raf_pkg::*;

    localparam int COORD_W  = COORD_BITS_DEFAULT;
    localparam int CFG_W    = (COORD_W > RADIUS_BITS) ? COORD_W : RADIUS_BITS;
    // no acceptance and no result for this many cycles means the block hung
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 155;

    // one pixel as the sender hands it over
    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
    } pixel_t;

    // all block inputs start at known values
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [ALPHA_BITS-1:0] pixel_alpha = '0;
    logic [COORD_W-1:0]    pixel_row   = '0;
    logic [COORD_W-1:0]    pixel_col   = '0;
    logic                  cfg_write   = 1'b0;
    logic [1:0]            cfg_index   = REG_MAX_ALPHA;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  busy;
    logic                  done;
    logic [ALPHA_BITS-1:0] new_alpha;

    radial_alpha_falloff #(
        .COORD_BITS (COORD_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_alpha (pixel_alpha),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .done        (done),
        .new_alpha   (new_alpha),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow copy of the block's registers, starting at reset values
    logic [ALPHA_BITS-1:0]  shadow_max_alpha  = MAX_ALPHA_RESET;
    logic [RADIUS_BITS-1:0] shadow_radius     = RADIUS_RESET;
    logic [COORD_W-1:0]     shadow_center_col = '0;
    logic [COORD_W-1:0]     shadow_center_row = '0;

    pixel_t                pixel_q[$];        // pixels waiting to be sent
    logic [ALPHA_BITS-1:0] alpha_expect_q[$]; // predicted alphas, oldest first
    logic                  item_taken = 1'b0; // start/busy handshake fired at last edge
    int                    burst_left = 1;
    int                    gap_left   = 0;
    int                    pixels_queued  = 0;
    int                    alphas_checked = 0;
    int                    error_count    = 0;
    int                    settings_used  = 0;

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // attenuated alpha of one pixel under the shadow registers
    function automatic logic [ALPHA_BITS-1:0] falloff_alpha(input pixel_t px);
        longint unsigned radius;
        longint unsigned recip;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned atten;
        longint unsigned scaled;
        longint unsigned result;
        // transparent pixels stay transparent
        if (px.alpha == '0)
            return '0;
        // a zero radius acts as one
        radius = (shadow_radius == '0) ? 1 : shadow_radius;
        recip  = DIVIDEND / radius;
        dx = (shadow_center_col >= px.col) ? shadow_center_col - px.col
                                           : px.col - shadow_center_col;
        dy = (shadow_center_row >= px.row) ? shadow_center_row - px.row
                                           : px.row - shadow_center_row;
        sq = dx * dx + dy * dy;
        // floor square root, two bits of the radicand per step
        root  = 0;
        probe = 64'd1 << 40;
        while (probe > sq)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (sq >= root + probe)
            begin
                sq   = sq - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        atten  = (root * recip) >> ATTEN_SHIFT;
        scaled = (px.alpha * shadow_max_alpha) >> ALPHA_BITS;
        result = (scaled > atten) ? scaled - atten : 0;
        // mirrors the clamp in raf_back, never fires
        if (result > px.alpha)
            result = 0;
        return result[ALPHA_BITS-1:0];
    endfunction

    // acceptance and result checking share one edge so a push always
    // lands before a same-edge result would look for it
    always @(posedge clk)
    begin
        pixel_t px;
        logic [ALPHA_BITS-1:0] want;
        px = '{alpha: pixel_alpha, row: pixel_row, col: pixel_col};
        if (rst_n && start && !busy)
            alpha_expect_q.push_back(falloff_alpha(px));
        item_taken <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (alpha_expect_q.size() == 0)
            begin
                $error("new_alpha: result with no pending item, actual %0d", new_alpha);
                error_count++;
            end
            else
            begin
                want = alpha_expect_q.pop_front();
                alphas_checked++;
                if (new_alpha !== want)
                begin
                    $error("new_alpha mismatch: expected %0d, actual %0d", want, new_alpha);
                    error_count++;
                end
            end
        end
    end

    // sender: bursts of items with random gaps, fields change on the falling edge
    always @(negedge clk)
    begin
        pixel_t px;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !item_taken)
        begin
            // item still offered, hold everything steady
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            start       <= 1'b0;
            pixel_alpha <= ALPHA_BITS'($urandom);
            pixel_row   <= COORD_W'($urandom);
            pixel_col   <= COORD_W'($urandom);
        end
        else if (pixel_q.size() > 0)
        begin
            px = pixel_q.pop_front();
            start       <= 1'b1;
            pixel_alpha <= px.alpha;
            pixel_row   <= px.row;
            pixel_col   <= px.col;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                // about a quarter of the bursts run straight into the next
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // hang detector: counts cycles in which neither side moves anything
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no item taken and no result for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one register write; write enable stays up across back-to-back writes
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MAX_ALPHA:  shadow_max_alpha  = data[ALPHA_BITS-1:0];
            REG_RADIUS:     shadow_radius     = data[RADIUS_BITS-1:0];
            REG_CENTER_COL: shadow_center_col = data[COORD_W-1:0];
            REG_CENTER_ROW: shadow_center_row = data[COORD_W-1:0];
            default: ;
        endcase
    endtask

    // full register setting, only called with nothing in flight
    task automatic program_regs(input int max_a, input int rad,
                                input int ccol, input int crow);
        write_reg(REG_MAX_ALPHA, CFG_W'(max_a));
        write_reg(REG_RADIUS, CFG_W'(rad));
        write_reg(REG_CENTER_COL, CFG_W'(ccol));
        write_reg(REG_CENTER_ROW, CFG_W'(crow));
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
        settings_used++;
    endtask

    task automatic queue_pixel(input int a, input int row, input int col);
        pixel_q.push_back('{alpha: a[ALPHA_BITS-1:0], row: row[COORD_W-1:0],
                            col: col[COORD_W-1:0]});
        pixels_queued++;
    endtask

    // block until every queued pixel has come back
    task automatic drain;
        do
            @(negedge clk);
        while (alphas_checked < pixels_queued);
    endtask

    initial
    begin
        int max_sel;
        int rad_sel;
        int max_a;
        int rad;
        int ccol;
        int crow;
        int spread;
        int kind;
        int a;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset values: radius 256, center at the origin, full scale
        settings_used = 1;
        queue_pixel(0, 0, 0);          // transparent pixel at the center
        queue_pixel(0, 4095, 4095);    // transparent pixel at the far corner
        queue_pixel(255, 0, 0);        // opaque at the center, no attenuation
        queue_pixel(1, 0, 0);          // scaling drops the alpha to 0
        queue_pixel(255, 4095, 4095);  // farthest point, clamps at 0
        queue_pixel(255, 0, 255);      // attenuation just above the scaled alpha, clamps at 0
        queue_pixel(255, 0, 100);
        queue_pixel(128, 60, 80);
        queue_pixel(200, 3, 4);
        drain();

        // radius 1: steepest falloff
        program_regs(255, 1, 0, 0);
        queue_pixel(255, 0, 0);
        queue_pixel(255, 0, 1);
        queue_pixel(17, 0, 0);
        drain();

        // zero scale, widest radius, center in the far corner
        program_regs(0, 8191, 4095, 4095);
        queue_pixel(255, 4095, 4095);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 10, 10);
        drain();

        // zero radius acts as one
        program_regs(128, 0, 2048, 1024);
        queue_pixel(255, 1024, 2048);
        queue_pixel(255, 1024, 2049);
        queue_pixel(99, 1024, 2048);
        drain();

        // gentle falloff around an off-center point
        program_regs(255, 8191, 2000, 3000);
        queue_pixel(255, 3000, 2000);
        queue_pixel(255, 0, 0);
        queue_pixel(170, 3100, 1900);
        queue_pixel(255, 4095, 4095);
        drain();

        // random settings, pixels clustered mostly around the center so
        // that the attenuated alpha is often nonzero
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            max_sel = $urandom_range(0, 5);
            max_a = (max_sel == 0) ? 0 : (max_sel == 1) ? 255 : $urandom_range(0, 255);
            rad_sel = $urandom_range(0, 9);
            if (rad_sel == 0)
                rad = 0;
            else if (rad_sel == 1)
                rad = $urandom_range(1, 8);
            else if (rad_sel == 2)
                rad = $urandom_range(0, 8191);
            else
                rad = $urandom_range(256, 8191);
            // the spare top bit of the data word is ignored for centers
            ccol = $urandom_range(0, 8191);
            crow = $urandom_range(0, 8191);
            program_regs(max_a, rad, ccol, crow);
            spread = (rad > 1500) ? 1500 : ((rad < 4) ? 4 : rad);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind = $urandom_range(0, 9);
                a = (kind == 0) ? 0 : (kind == 1) ? 255 : $urandom_range(1, 255);
                if (kind < 6)
                    queue_pixel(a, crow + $urandom_range(0, 2 * spread) - spread,
                                ccol + $urandom_range(0, 2 * spread) - spread);
                else
                    queue_pixel($urandom_range(0, 255), $urandom_range(0, 4095),
                                $urandom_range(0, 4095));
            end
            drain();
        end

        // let any stray result show up before judging
        repeat (LATENCY + 4) @(posedge clk);
        if (alpha_expect_q.size() != 0)
        begin
            $error("new_alpha: %0d predicted results never arrived", alpha_expect_q.size());
            error_count++;
        end

        $display("covered %0d pixels under %0d register settings, %0d results checked",
                 pixels_queued, settings_used, alphas_checked);
        $display("settings included zero scale, zero and extreme radius, corner centers");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
